// ===== sv/session_locked_mailbox_queue_defines.svh =====
// assertion macros shared by the mailbox queue rtl
// no dependencies; included by the modules that check their own logic
`ifndef SESSION_LOCKED_MAILBOX_QUEUE_DEFINES_SVH
`define SESSION_LOCKED_MAILBOX_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SLMQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SLMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/slmq_pkg.sv =====
// types and codes for the session locked mailbox queue
// used by slmq_ctrl, slmq_dp and the top level; no dependencies
`default_nettype none

package slmq_pkg;

	localparam int unsigned SESS_W = 32;
	localparam int unsigned SRC_W  = 32;
	localparam int unsigned SIZE_W = 32;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned HDL_W  = 32;

	// operation codes
	typedef enum logic [2:0] {
		ACT_PUSH     = 3'd0,
		ACT_POP      = 3'd1,
		ACT_LOCK     = 3'd2,
		ACT_UNLOCK   = 3'd3,
		ACT_REQUEUE  = 3'd4,
		ACT_MARK_REL = 3'd5,
		ACT_CHECK    = 3'd6,
		ACT_LENGTH   = 3'd7
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_ERR   = 2'd3
	} status_t;

	// scheduling mark
	typedef enum logic [1:0] {
		MARK_IDLE   = 2'd0,
		MARK_LISTED = 2'd1,
		MARK_DISP   = 2'd2,
		MARK_LOCKED = 2'd3
	} mark_t;

	// controller states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

	// one ring entry
	typedef struct packed {
		logic [SESS_W-1:0] session;
		logic [SRC_W-1:0]  source;
		logic [SIZE_W-1:0] size;
		logic [DATA_W-1:0] data;
	} entry_t;

endpackage

`default_nettype wire

// ===== sv/session_locked_mailbox_queue.sv =====
// Per-service mailbox queue with session lock and scheduling mark.
// A command taken on start with busy low is latched, executed while busy is high,
// and its result is then marked by done for one cycle; results cannot be stalled.
// No command is taken while busy: each has its transfer cycle, then the execute
// cycle in which the ring and pointers update while busy stays high.
// Reset (arst_n low, asynchronous): ring empty, mark listed, no lock, handle 0.
`default_nettype none

module session_locked_mailbox_queue #(
	parameter int unsigned QUEUE_DEPTH = 64
) (
	input  wire logic                                                clk,
	input  wire logic                                                arst_n,
	input  wire logic                                                start,
	output logic                                                     busy,
	input  wire logic [2:0]                                          action,
	input  wire logic signed [slmq_pkg::SESS_W-1:0]                  msg_session,
	input  wire logic [slmq_pkg::SRC_W-1:0]                          msg_source,
	input  wire logic [slmq_pkg::SIZE_W-1:0]                         msg_size,
	input  wire logic [slmq_pkg::DATA_W-1:0]                         msg_data,
	input  wire logic                                                cfg_valid,
	output logic                                                     cfg_ready,
	input  wire logic [slmq_pkg::HDL_W-1:0]                          cfg_data,
	output logic                                                     done,
	output logic [1:0]                                               status,
	output logic signed [slmq_pkg::SESS_W-1:0]                       out_session,
	output logic [slmq_pkg::SRC_W-1:0]                               out_source,
	output logic [slmq_pkg::SIZE_W-1:0]                              out_size,
	output logic [slmq_pkg::DATA_W-1:0]                              out_data,
	output logic                                                     schedule,
	output logic                                                     drop,
	output logic [1:0]                                               sched_mark,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]                         fill_level,
	output logic [slmq_pkg::HDL_W-1:0]                               owner_handle
);

	slmq_pkg::dp_cmd_t cmd;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// sequencing
	slmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// ring and mailbox state
	slmq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       ($clog2(QUEUE_DEPTH + 1))
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.msg_session  (msg_session),
		.msg_source   (msg_source),
		.msg_size     (msg_size),
		.msg_data     (msg_data),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.status       (status),
		.out_session  (out_session),
		.out_source   (out_source),
		.out_size     (out_size),
		.out_data     (out_data),
		.schedule     (schedule),
		.drop         (drop),
		.sched_mark   (sched_mark),
		.fill_level   (fill_level),
		.owner_handle (owner_handle)
	);

endmodule

`default_nettype wire

// ===== sv/slmq_ctrl.sv =====
// controller for the mailbox queue: accept, execute, result strobe
// depends on slmq_pkg and session_locked_mailbox_queue_defines.svh
`default_nettype none
`include "session_locked_mailbox_queue_defines.svh"

module slmq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output slmq_pkg::dp_cmd_t      cmd
);

	slmq_pkg::ctrl_state_t state_q;
	logic                  done_q;

	assign busy     = (state_q == slmq_pkg::ST_EXEC);
	assign cmd.load = start && !busy;
	assign cmd.exec = busy;
	assign done     = done_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slmq_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			unique case (state_q)
				slmq_pkg::ST_IDLE: begin
					if (start) state_q <= slmq_pkg::ST_EXEC;
				end
				slmq_pkg::ST_EXEC: begin
					state_q <= slmq_pkg::ST_IDLE;
				end
				default: begin
					state_q <= slmq_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// the result strobe follows execution and never overlaps it
	`SLMQ_ASSERT_NOW(a_done_not_busy, clk, arst_n, done_q, !busy, "strobe during execution")
	`SLMQ_ASSERT_NEXT(a_exec_then_done, clk, arst_n, cmd.exec, done_q && !busy, "missing strobe")
	`SLMQ_ASSERT_NOW(a_state_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")

endmodule

`default_nettype wire

// ===== sv/slmq_dp.sv =====
// datapath for the mailbox queue: ring memory, pointers, mark and lock state
// depends on slmq_pkg and session_locked_mailbox_queue_defines.svh
`default_nettype none
`include "session_locked_mailbox_queue_defines.svh"

module slmq_dp #(
	parameter int unsigned QUEUE_DEPTH = 64,
	parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire slmq_pkg::dp_cmd_t                    cmd,
	input  wire logic [2:0]                           action,
	input  wire logic signed [slmq_pkg::SESS_W-1:0]   msg_session,
	input  wire logic [slmq_pkg::SRC_W-1:0]           msg_source,
	input  wire logic [slmq_pkg::SIZE_W-1:0]          msg_size,
	input  wire logic [slmq_pkg::DATA_W-1:0]          msg_data,
	input  wire logic                                 cfg_we,
	input  wire logic [slmq_pkg::HDL_W-1:0]           cfg_data,
	output logic [1:0]                                status,
	output logic signed [slmq_pkg::SESS_W-1:0]        out_session,
	output logic [slmq_pkg::SRC_W-1:0]                out_source,
	output logic [slmq_pkg::SIZE_W-1:0]               out_size,
	output logic [slmq_pkg::DATA_W-1:0]               out_data,
	output logic                                      schedule,
	output logic                                      drop,
	output logic [1:0]                                sched_mark,
	output logic [CNT_W-1:0]                          fill_level,
	output logic [slmq_pkg::HDL_W-1:0]                owner_handle
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	// ring memory
	slmq_pkg::entry_t mem [QUEUE_DEPTH];

	// latched item
	slmq_pkg::action_t            act_q;
	slmq_pkg::entry_t             item_q;

	// mailbox state
	logic [IDX_W-1:0]             head_q, tail_q;
	logic [CNT_W-1:0]             cnt_q;
	slmq_pkg::mark_t              mark_q;
	logic [slmq_pkg::SESS_W-1:0]  lock_q;
	logic                         rel_q;
	logic [slmq_pkg::HDL_W-1:0]   handle_q;

	// result registers
	slmq_pkg::status_t            status_q;
	logic                         sched_q, drop_q, pop_q;
	slmq_pkg::entry_t             rd_q;

	// next-state values
	logic [IDX_W-1:0]             head_n, tail_n, waddr, head_m1, head_p1, tail_p1;
	logic [CNT_W-1:0]             cnt_n;
	slmq_pkg::mark_t              mark_n, mark_rq;
	logic [slmq_pkg::SESS_W-1:0]  lock_n;
	logic                         rel_n, we, sched_n, drop_n, pop_n, head_hit, full;
	slmq_pkg::status_t            status_n;

	// pointer neighbors with wrap
	assign head_m1  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_p1  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_p1  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign full     = (cnt_q >= FULL_CNT);
	assign head_hit = (lock_q != '0) && (item_q.session == lock_q);

	// requeue mark update
	always_comb begin
		mark_rq = mark_q;
		if (mark_q == slmq_pkg::MARK_DISP) mark_rq = slmq_pkg::MARK_LOCKED;
		if (lock_q == '0) mark_rq = slmq_pkg::MARK_LISTED;
	end

	// operation decode
	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		cnt_n    = cnt_q;
		mark_n   = mark_q;
		lock_n   = lock_q;
		rel_n    = rel_q;
		status_n = slmq_pkg::STAT_OK;
		sched_n  = 1'b0;
		drop_n   = 1'b0;
		pop_n    = 1'b0;
		we       = 1'b0;
		waddr    = tail_q;
		unique case (act_q)
			slmq_pkg::ACT_PUSH: begin
				if (head_hit) begin
					if (mark_q != slmq_pkg::MARK_DISP && mark_q != slmq_pkg::MARK_LOCKED) begin
						status_n = slmq_pkg::STAT_ERR;
					end else if (full) begin
						status_n = slmq_pkg::STAT_FULL;
					end else begin
						we     = 1'b1;
						waddr  = head_m1;
						head_n = head_m1;
						cnt_n  = cnt_q + 1'b1;
						lock_n = '0;
						if (mark_q == slmq_pkg::MARK_LOCKED) begin
							sched_n = 1'b1;
							mark_n  = slmq_pkg::MARK_LISTED;
						end
					end
				end else if (full) begin
					status_n = slmq_pkg::STAT_FULL;
				end else begin
					we     = 1'b1;
					tail_n = tail_p1;
					cnt_n  = cnt_q + 1'b1;
					if (lock_q == '0 && mark_q == slmq_pkg::MARK_IDLE) begin
						sched_n = 1'b1;
						mark_n  = slmq_pkg::MARK_LISTED;
					end
				end
			end
			slmq_pkg::ACT_POP: begin
				if (cnt_q != '0) begin
					pop_n  = 1'b1;
					head_n = head_p1;
					cnt_n  = cnt_q - 1'b1;
				end else begin
					status_n = slmq_pkg::STAT_EMPTY;
					mark_n   = slmq_pkg::MARK_IDLE;
				end
			end
			slmq_pkg::ACT_LOCK: begin
				if (lock_q != '0 || mark_q != slmq_pkg::MARK_LISTED) begin
					status_n = slmq_pkg::STAT_ERR;
				end else begin
					mark_n = slmq_pkg::MARK_DISP;
					lock_n = item_q.session;
				end
			end
			slmq_pkg::ACT_UNLOCK: begin
				if (mark_q == slmq_pkg::MARK_LOCKED) begin
					sched_n = 1'b1;
					mark_n  = slmq_pkg::MARK_LISTED;
					lock_n  = '0;
				end else if (mark_q == slmq_pkg::MARK_DISP) begin
					lock_n = '0;
				end else begin
					status_n = slmq_pkg::STAT_ERR;
				end
			end
			slmq_pkg::ACT_REQUEUE: begin
				if (mark_q == slmq_pkg::MARK_IDLE) begin
					status_n = slmq_pkg::STAT_ERR;
				end else begin
					mark_n  = mark_rq;
					sched_n = (lock_q == '0);
				end
			end
			slmq_pkg::ACT_MARK_REL: begin
				if (rel_q) begin
					status_n = slmq_pkg::STAT_ERR;
				end else begin
					rel_n   = 1'b1;
					sched_n = (mark_q != slmq_pkg::MARK_LISTED);
				end
			end
			slmq_pkg::ACT_CHECK: begin
				if (rel_q) begin
					head_n = '0;
					tail_n = '0;
					cnt_n  = '0;
					mark_n = slmq_pkg::MARK_IDLE;
					lock_n = '0;
					rel_n  = 1'b0;
					drop_n = 1'b1;
				end else if (mark_q == slmq_pkg::MARK_IDLE) begin
					status_n = slmq_pkg::STAT_ERR;
				end else begin
					sched_n = 1'b1;
				end
			end
			slmq_pkg::ACT_LENGTH: begin
			end
			default: begin
			end
		endcase
	end

	// item latch on transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q          <= slmq_pkg::action_t'(action);
			item_q.session <= msg_session;
			item_q.source  <= msg_source;
			item_q.size    <= msg_size;
			item_q.data    <= msg_data;
		end
	end

	// ring write and head read
	always_ff @(posedge clk) begin
		if (cmd.exec && we) mem[waddr] <= item_q;
		if (cmd.exec) rd_q <= mem[head_q];
	end

	// mailbox state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
			mark_q   <= slmq_pkg::MARK_LISTED;
			lock_q   <= '0;
			rel_q    <= 1'b0;
			handle_q <= '0;
			status_q <= slmq_pkg::STAT_OK;
			sched_q  <= 1'b0;
			drop_q   <= 1'b0;
			pop_q    <= 1'b0;
		end else begin
			if (cfg_we) handle_q <= cfg_data;
			if (cmd.exec) begin
				head_q   <= head_n;
				tail_q   <= tail_n;
				cnt_q    <= cnt_n;
				mark_q   <= mark_n;
				lock_q   <= lock_n;
				rel_q    <= rel_n;
				status_q <= status_n;
				sched_q  <= sched_n;
				drop_q   <= drop_n;
				pop_q    <= pop_n;
			end
		end
	end

	// result outputs; message fields are zero unless a pop succeeded
	assign status       = status_q;
	assign schedule     = sched_q;
	assign drop         = drop_q;
	assign sched_mark   = mark_q;
	assign fill_level   = cnt_q;
	assign owner_handle = handle_q;
	assign out_session  = pop_q ? $signed(rd_q.session) : '0;
	assign out_source   = pop_q ? rd_q.source : '0;
	assign out_size     = pop_q ? rd_q.size : '0;
	assign out_data     = pop_q ? rd_q.data : '0;

	`SLMQ_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= FULL_CNT, "fill count overflow")
	`SLMQ_ASSERT_NEXT(a_drop_clears, clk, arst_n, cmd.exec && drop_n, cnt_q == '0 && mark_q == slmq_pkg::MARK_IDLE && !rel_q, "release check left state")
	`SLMQ_ASSERT_NEXT(a_err_holds, clk, arst_n, cmd.exec && status_n == slmq_pkg::STAT_ERR, $stable(cnt_q) && $stable(head_q) && $stable(tail_q) && $stable(lock_q), "failed check changed ring")

endmodule

`default_nettype wire

// ===== sim/session_locked_mailbox_queue_tb.sv =====
// self-checking testbench for the session locked mailbox queue
// needs slmq_pkg and session_locked_mailbox_queue; holds its own mailbox predictor
`timescale 1ns / 1ps

module session_locked_mailbox_queue_tb;

	localparam int unsigned RING_DEPTH   = 64;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned PHASE_ITEMS  = 650;

	// one command as driven on the ports
	typedef struct {
		slmq_pkg::action_t  act;
		logic signed [31:0] session;
		logic [31:0]        source;
		logic [31:0]        size;
		logic [63:0]        data;
	} mb_cmd_t;

	// one result as seen on the ports
	typedef struct {
		slmq_pkg::status_t  st;
		logic signed [31:0] session;
		logic [31:0]        source;
		logic [31:0]        size;
		logic [63:0]        data;
		logic               sched;
		logic               drop;
		slmq_pkg::mark_t    mark;
		logic [6:0]         fill;
		logic [31:0]        owner;
	} mb_result_t;

	// mailbox predictor and store of expected results
	class mailbox_scoreboard;
		logic signed [31:0] ring_session [RING_DEPTH];
		logic [31:0]        ring_source [RING_DEPTH];
		logic [31:0]        ring_size [RING_DEPTH];
		logic [63:0]        ring_data [RING_DEPTH];
		int unsigned        head_pos = 0;
		int unsigned        tail_pos = 0;
		int unsigned        count = 0;
		slmq_pkg::mark_t    mark = slmq_pkg::MARK_LISTED;
		logic signed [31:0] lock_sess = 0;
		bit                 release_set = 0;
		logic [31:0]        handle = 0;
		mb_result_t         expected_q[$];
		int                 errors = 0;

		function void set_handle(logic [31:0] v);
			handle = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		function void write_slot(int unsigned slot, mb_cmd_t c);
			ring_session[slot] = c.session;
			ring_source[slot]  = c.source;
			ring_size[slot]    = c.size;
			ring_data[slot]    = c.data;
		endfunction

		// work out the result of one accepted command and update the mailbox
		function void note_command(mb_cmd_t c);
			mb_result_t r;
			r.st = slmq_pkg::STAT_OK;
			r.session = '0;
			r.source = '0;
			r.size = '0;
			r.data = '0;
			r.sched = 1'b0;
			r.drop = 1'b0;
			case (c.act)
				slmq_pkg::ACT_PUSH: begin
					if (lock_sess != 0 && c.session == lock_sess) begin
						// reply to the locked session goes to the head
						if (mark != slmq_pkg::MARK_DISP && mark != slmq_pkg::MARK_LOCKED) begin
							r.st = slmq_pkg::STAT_ERR;
						end else if (count >= RING_DEPTH) begin
							r.st = slmq_pkg::STAT_FULL;
						end else begin
							head_pos = (head_pos + RING_DEPTH - 1) % RING_DEPTH;
							write_slot(head_pos, c);
							count++;
							if (mark == slmq_pkg::MARK_LOCKED) begin
								r.sched = 1'b1;
								mark = slmq_pkg::MARK_LISTED;
							end
							lock_sess = 0;
						end
					end else if (count >= RING_DEPTH) begin
						r.st = slmq_pkg::STAT_FULL;
					end else begin
						write_slot(tail_pos, c);
						tail_pos = (tail_pos + 1) % RING_DEPTH;
						count++;
						if (lock_sess == 0 && mark == slmq_pkg::MARK_IDLE) begin
							mark = slmq_pkg::MARK_LISTED;
							r.sched = 1'b1;
						end
					end
				end
				slmq_pkg::ACT_POP: begin
					if (count != 0) begin
						r.session = ring_session[head_pos];
						r.source = ring_source[head_pos];
						r.size = ring_size[head_pos];
						r.data = ring_data[head_pos];
						head_pos = (head_pos + 1) % RING_DEPTH;
						count--;
					end else begin
						r.st = slmq_pkg::STAT_EMPTY;
						mark = slmq_pkg::MARK_IDLE;
					end
				end
				slmq_pkg::ACT_LOCK: begin
					if (lock_sess != 0 || mark != slmq_pkg::MARK_LISTED) begin
						r.st = slmq_pkg::STAT_ERR;
					end else begin
						mark = slmq_pkg::MARK_DISP;
						lock_sess = c.session;
					end
				end
				slmq_pkg::ACT_UNLOCK: begin
					if (mark == slmq_pkg::MARK_LOCKED) begin
						r.sched = 1'b1;
						mark = slmq_pkg::MARK_LISTED;
						lock_sess = 0;
					end else if (mark == slmq_pkg::MARK_DISP) begin
						lock_sess = 0;
					end else begin
						r.st = slmq_pkg::STAT_ERR;
					end
				end
				slmq_pkg::ACT_REQUEUE: begin
					if (mark == slmq_pkg::MARK_IDLE) begin
						r.st = slmq_pkg::STAT_ERR;
					end else begin
						if (mark == slmq_pkg::MARK_DISP)
							mark = slmq_pkg::MARK_LOCKED;
						if (lock_sess == 0) begin
							r.sched = 1'b1;
							mark = slmq_pkg::MARK_LISTED;
						end
					end
				end
				slmq_pkg::ACT_MARK_REL: begin
					if (release_set) begin
						r.st = slmq_pkg::STAT_ERR;
					end else begin
						release_set = 1'b1;
						if (mark != slmq_pkg::MARK_LISTED)
							r.sched = 1'b1;
					end
				end
				slmq_pkg::ACT_CHECK: begin
					if (release_set) begin
						// release found: empty the ring and drop the mailbox
						head_pos = 0;
						tail_pos = 0;
						count = 0;
						mark = slmq_pkg::MARK_IDLE;
						lock_sess = 0;
						release_set = 1'b0;
						r.drop = 1'b1;
					end else if (mark == slmq_pkg::MARK_IDLE) begin
						r.st = slmq_pkg::STAT_ERR;
					end else begin
						r.sched = 1'b1;
					end
				end
				default: begin
				end
			endcase
			r.mark = mark;
			r.fill = 7'(count);
			r.owner = handle;
			expected_q.push_back(r);
		endfunction

		// compare one observed result with the oldest expectation
		task check_result(mb_result_t got);
			mb_result_t w;
			if (expected_q.size() == 0) begin
				report_mismatch("result with no command outstanding");
			end else begin
				w = expected_q.pop_front();
				if (got.st !== w.st)
					report_mismatch($sformatf("status %0d want %0d", got.st, w.st));
				if (got.session !== w.session)
					report_mismatch($sformatf("out_session %h want %h", got.session, w.session));
				if (got.source !== w.source)
					report_mismatch($sformatf("out_source %h want %h", got.source, w.source));
				if (got.size !== w.size)
					report_mismatch($sformatf("out_size %h want %h", got.size, w.size));
				if (got.data !== w.data)
					report_mismatch($sformatf("out_data %h want %h", got.data, w.data));
				if (got.sched !== w.sched)
					report_mismatch($sformatf("schedule %b want %b", got.sched, w.sched));
				if (got.drop !== w.drop)
					report_mismatch($sformatf("drop %b want %b", got.drop, w.drop));
				if (got.mark !== w.mark)
					report_mismatch($sformatf("sched_mark %0d want %0d", got.mark, w.mark));
				if (got.fill !== w.fill)
					report_mismatch($sformatf("fill_level %0d want %0d", got.fill, w.fill));
				if (got.owner !== w.owner)
					report_mismatch($sformatf("owner_handle %h want %h", got.owner, w.owner));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         action = '0;
	logic signed [31:0] msg_session = '0;
	logic [31:0]        msg_source = '0;
	logic [31:0]        msg_size = '0;
	logic [63:0]        msg_data = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [31:0]        cfg_data = '0;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] out_session;
	logic [31:0]        out_source;
	logic [31:0]        out_size;
	logic [63:0]        out_data;
	logic               schedule;
	logic               drop;
	logic [1:0]         sched_mark;
	logic [6:0]         fill_level;
	logic [31:0]        owner_handle;

	mailbox_scoreboard sb = new();
	int unsigned       cycle_count = 0;
	int unsigned       sent_count = 0;
	int unsigned       idle_pct = 0;

	session_locked_mailbox_queue #(
		.QUEUE_DEPTH(RING_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.msg_session(msg_session),
		.msg_source(msg_source),
		.msg_size(msg_size),
		.msg_data(msg_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.out_session(out_session),
		.out_source(out_source),
		.out_size(out_size),
		.out_data(out_data),
		.schedule(schedule),
		.drop(drop),
		.sched_mark(sched_mark),
		.fill_level(fill_level),
		.owner_handle(owner_handle)
	);

	// 10 ns clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result monitor: one result per done strobe
	always @(posedge clk) begin
		mb_result_t got;
		if (arst_n && done) begin
			got.st = slmq_pkg::status_t'(status);
			got.session = out_session;
			got.source = out_source;
			got.size = out_size;
			got.data = out_data;
			got.sched = schedule;
			got.drop = drop;
			got.mark = slmq_pkg::mark_t'(sched_mark);
			got.fill = fill_level;
			got.owner = owner_handle;
			sb.check_result(got);
		end
	end

	function automatic mb_cmd_t make_cmd(slmq_pkg::action_t a, logic signed [31:0] s);
		mb_cmd_t c;
		c.act = a;
		c.session = s;
		c.source = $urandom;
		c.size = $urandom;
		c.data = {$urandom, $urandom};
		return c;
	endfunction

	// sessions lean on the locked one so that replies reach the head
	function automatic logic signed [31:0] pick_session();
		int unsigned r;
		r = $urandom_range(9);
		if (sb.lock_sess != 0 && r < 4)
			return sb.lock_sess;
		case (r)
			4: return 0;
			5: return $urandom_range(1, 4);
			6: return 32'sh7fff_ffff;
			7: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// random sender gap before a command
	task automatic sender_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// drive one command and wait for its transfer
	task automatic send_command(mb_cmd_t c);
		sender_gap();
		start <= 1'b1;
		action <= c.act;
		msg_session <= c.session;
		msg_source <= c.source;
		msg_size <= c.size;
		msg_data <= c.data;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(c);
		sent_count++;
	endtask

	task automatic send_random(slmq_pkg::action_t a);
		send_command(make_cmd(a, pick_session()));
	endtask

	// stop sending until every outstanding result has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// owner handle write, only while the block is idle
	task automatic write_handle(logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.set_handle(v);
	endtask

	// directed: extremes of the payload and each corner of the mark scheme
	task automatic run_directed();
		mb_cmd_t c;
		send_random(slmq_pkg::ACT_LENGTH);
		send_random(slmq_pkg::ACT_POP);               // empty pop, mark goes idle
		send_random(slmq_pkg::ACT_REQUEUE);           // requeue while idle
		send_random(slmq_pkg::ACT_UNLOCK);            // unlock while idle
		send_random(slmq_pkg::ACT_CHECK);             // check while idle, no release
		c = make_cmd(slmq_pkg::ACT_PUSH, 32'h8000_0000); // tail push lists an idle mailbox
		c.source = '0;
		c.size = '1;
		c.data = '0;
		send_command(c);
		c = make_cmd(slmq_pkg::ACT_PUSH, 32'sh7fff_ffff);
		c.source = '1;
		c.size = '0;
		c.data = '1;
		send_command(c);
		send_random(slmq_pkg::ACT_UNLOCK);            // unlock while listed
		send_command(make_cmd(slmq_pkg::ACT_LOCK, 0)); // lock of session zero
		send_command(make_cmd(slmq_pkg::ACT_LOCK, 5)); // lock while dispatching
		send_random(slmq_pkg::ACT_REQUEUE);           // no lock, back to listed
		send_command(make_cmd(slmq_pkg::ACT_LOCK, -1));
		send_command(make_cmd(slmq_pkg::ACT_PUSH, -1)); // head push while dispatching
		send_random(slmq_pkg::ACT_REQUEUE);
		send_command(make_cmd(slmq_pkg::ACT_LOCK, 7));
		send_random(slmq_pkg::ACT_REQUEUE);           // dispatching to locked
		send_command(make_cmd(slmq_pkg::ACT_PUSH, 7)); // head push ends the lock
		send_random(slmq_pkg::ACT_POP);
		send_random(slmq_pkg::ACT_MARK_REL);
		send_random(slmq_pkg::ACT_MARK_REL);          // already marked
		send_random(slmq_pkg::ACT_CHECK);             // release found, ring dropped
		send_random(slmq_pkg::ACT_MARK_REL);          // mark release while idle
		send_command(make_cmd(slmq_pkg::ACT_PUSH, 3));
		send_random(slmq_pkg::ACT_CHECK);
		send_random(slmq_pkg::ACT_CHECK);
	endtask

	// one dispatch round as a scheduler would run it
	task automatic dispatch_round();
		logic signed [31:0] s;
		repeat ($urandom_range(0, 4))
			send_random(slmq_pkg::ACT_PUSH);
		s = ($urandom_range(3) == 0) ? 32'sd0 : $urandom_range(1, 6);
		send_command(make_cmd(slmq_pkg::ACT_LOCK, s));
		repeat ($urandom_range(0, 3))
			send_random(slmq_pkg::ACT_POP);
		if ($urandom_range(1))
			send_command(make_cmd(slmq_pkg::ACT_PUSH, s));
		case ($urandom_range(2))
			0: send_random(slmq_pkg::ACT_REQUEUE);
			1: send_random(slmq_pkg::ACT_UNLOCK);
			default: begin
				send_random(slmq_pkg::ACT_UNLOCK);
				send_random(slmq_pkg::ACT_REQUEUE);
			end
		endcase
	endtask

	// fill the ring to the brim, optionally under a lock, then maybe drain it
	task automatic fill_burst();
		logic signed [31:0] s;
		s = $urandom_range(1, 9);
		if ($urandom_range(1))
			send_command(make_cmd(slmq_pkg::ACT_LOCK, s));
		while (sb.count < RING_DEPTH)
			send_command(make_cmd(slmq_pkg::ACT_PUSH, $urandom_range(10, 1000)));
		send_command(make_cmd(slmq_pkg::ACT_PUSH, s));
		send_random(slmq_pkg::ACT_PUSH);
		if ($urandom_range(1)) begin
			while (sb.count > 0)
				send_random(slmq_pkg::ACT_POP);
			send_random(slmq_pkg::ACT_POP);
		end
	endtask

	task automatic run_phase(logic [31:0] hdl, int unsigned pct);
		int unsigned target;
		int unsigned next_hold;
		int unsigned pick;
		hold_until_drained();
		write_handle(hdl);
		idle_pct = pct;
		target = sent_count + PHASE_ITEMS;
		next_hold = sent_count + $urandom_range(100, 250);
		while (sent_count < target) begin
			if (sent_count >= next_hold) begin
				hold_until_drained();
				next_hold = sent_count + $urandom_range(100, 250);
			end
			pick = $urandom_range(99);
			if (pick < 60) begin
				dispatch_round();
			end else if (pick < 75) begin
				send_random(slmq_pkg::ACT_MARK_REL);
				repeat ($urandom_range(0, 3))
					send_random(slmq_pkg::action_t'($urandom_range(7)));
				send_random(slmq_pkg::ACT_CHECK);
				if ($urandom_range(3) == 0)
					send_random(slmq_pkg::ACT_CHECK);
			end else if (pick < 79) begin
				fill_burst();
			end else begin
				repeat ($urandom_range(1, 5))
					send_random(slmq_pkg::action_t'($urandom_range(7)));
			end
		end
	endtask

	// reset, phases, final verdict
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_handle(32'h0000_0000);
		idle_pct = 33;
		run_directed();
		run_phase(32'hffff_ffff, 33);
		run_phase($urandom, 80);
		run_phase(32'h0000_0001, 0);
		hold_until_drained();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== session_locked_mailbox_queue.f =====
+incdir+sv
sv/slmq_pkg.sv
sv/slmq_ctrl.sv
sv/slmq_dp.sv
sv/session_locked_mailbox_queue.sv
sim/session_locked_mailbox_queue_tb.sv
